// ----- rtl/core/tmcg_pkg.sv -----
package tmcg_pkg;

   localparam int CHAR_COUNT          = 256;
   localparam int GLYPH_ROWS_DEFAULT  = 32;
   localparam int FONT_BANKS_DEFAULT  = 2;
   localparam int CMDQ_DEPTH          = 4;
   localparam int OUT_DEPTH           = 4;
   localparam int ROW_W               = 5;
   localparam int CSR_INDEX_W         = 2;
   localparam int CSR_DATA_W          = 5;
   localparam int COLOR_W             = 4;
   localparam int PIXELS              = 8;
   localparam int BYTE_W              = 8;

   typedef enum logic [1:0] {
      KIND_FONT_WRITE = 2'd0,
      KIND_RENDER     = 2'd1,
      KIND_FRAME_TICK = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BLINK_ENABLE     = 2'd0,
      CSR_CURSOR_ENABLE    = 2'd1,
      CSR_CURSOR_START_ROW = 2'd2,
      CSR_CURSOR_END_ROW   = 2'd3
   } csr_index_type;

   // data holds the font byte on a write, {bg, fg} on a render
   typedef struct packed {
      logic              is_write;
      logic              glyph_off;
      logic              fill;
      logic [BYTE_W-1:0] data;
   } cmd_type;

   typedef logic [PIXELS-1:0][COLOR_W-1:0] pixel_row_type;

endpackage

// ----- rtl/core/tmcg_front.sv -----
module tmcg_front
   import tmcg_pkg::*;
#(
   parameter int GLYPH_ROWS = GLYPH_ROWS_DEFAULT,
   parameter int FONT_BANKS = FONT_BANKS_DEFAULT,
   localparam int ADDR_W = $clog2(FONT_BANKS * CHAR_COUNT * GLYPH_ROWS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic                   q_full,
   input  logic [1:0]             req_kind,
   input  logic [BYTE_W-1:0]      req_char_code,
   input  logic [BYTE_W-1:0]      req_attribute,
   input  logic [ROW_W-1:0]       req_row,
   input  logic                   req_is_cursor_cell,
   input  logic                   req_font_bank,
   input  logic [BYTE_W-1:0]      req_font_byte,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic                   q_push,
   output cmd_type                q_cmd,
   output logic [ADDR_W-1:0]      q_addr
);

   localparam int ENTRY_W = $clog2(FONT_BANKS * CHAR_COUNT);
   localparam int ROW_LIM_W = ROW_W + 1;
   localparam logic [ROW_LIM_W-1:0] ROW_LIMIT = ROW_LIM_W'(GLYPH_ROWS);
   localparam logic [ADDR_W-1:0] ROWS_A = ADDR_W'(GLYPH_ROWS);

   logic              blink_enable_ff, blink_enable_in;
   logic              cursor_enable_ff, cursor_enable_in;
   logic [ROW_W-1:0]  cursor_start_ff, cursor_start_in;
   logic [ROW_W-1:0]  cursor_end_ff, cursor_end_in;
   logic [BYTE_W-1:0] frame_count_ff, frame_count_in;

   logic               accept;
   logic               row_ok;
   logic               bank;
   logic [ENTRY_W-1:0] entry;
   logic [COLOR_W-1:0] bg;
   logic               cursor_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         blink_enable_ff  <= 1'b1;
         cursor_enable_ff <= 1'b0;
         cursor_start_ff  <= '0;
         cursor_end_ff    <= '0;
         frame_count_ff   <= '0;
      end else begin
         blink_enable_ff  <= blink_enable_in;
         cursor_enable_ff <= cursor_enable_in;
         cursor_start_ff  <= cursor_start_in;
         cursor_end_ff    <= cursor_end_in;
         frame_count_ff   <= frame_count_in;
      end
   end

   always_comb begin
      blink_enable_in  = blink_enable_ff;
      cursor_enable_in = cursor_enable_ff;
      cursor_start_in  = cursor_start_ff;
      cursor_end_in    = cursor_end_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_BLINK_ENABLE:     blink_enable_in  = csr_wdata[0];
            CSR_CURSOR_ENABLE:    cursor_enable_in = csr_wdata[0];
            CSR_CURSOR_START_ROW: cursor_start_in  = csr_wdata[ROW_W-1:0];
            CSR_CURSOR_END_ROW:   cursor_end_in    = csr_wdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   assign accept = req_push && !q_full;
   assign row_ok = {1'b0, req_row} < ROW_LIMIT;

   always_comb begin
      // bank numbers wrap when only one bank is built
      bank   = (kind_type'(req_kind) == KIND_FONT_WRITE) ? req_font_bank : req_attribute[3];
      entry  = ENTRY_W'({bank, req_char_code});
      q_addr = ADDR_W'(ADDR_W'(entry) * ROWS_A) + ADDR_W'(req_row);

      bg = req_attribute[7:4];
      if (blink_enable_ff) begin
         bg[COLOR_W-1] = 1'b0;
      end
      cursor_hit = cursor_enable_ff && frame_count_ff[3] && req_is_cursor_cell
                   && (req_row >= cursor_start_ff) && (req_row <= cursor_end_ff);

      frame_count_in  = frame_count_ff;
      q_push          = 1'b0;
      q_cmd.is_write  = 1'b0;
      q_cmd.glyph_off = 1'b0;
      q_cmd.fill      = 1'b0;
      q_cmd.data      = {bg, req_attribute[3:0]};
      unique case (kind_type'(req_kind))
         KIND_FONT_WRITE: begin
            q_push         = accept && row_ok;
            q_cmd.is_write = 1'b1;
            q_cmd.data     = req_font_byte;
         end
         KIND_RENDER: begin
            q_push          = accept;
            q_cmd.glyph_off = !row_ok
                              || (blink_enable_ff && req_attribute[7] && frame_count_ff[4]);
            q_cmd.fill      = cursor_hit;
         end
         KIND_FRAME_TICK: begin
            if (accept) begin
               frame_count_in = frame_count_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule

// ----- rtl/core/tmcg_cmdq.sv -----
module tmcg_cmdq
   import tmcg_pkg::*;
#(
   parameter int GLYPH_ROWS = GLYPH_ROWS_DEFAULT,
   parameter int FONT_BANKS = FONT_BANKS_DEFAULT,
   localparam int ADDR_W = $clog2(FONT_BANKS * CHAR_COUNT * GLYPH_ROWS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cmd_type           push_cmd,
   input  logic [ADDR_W-1:0] push_addr,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output cmd_type           head_cmd,
   output logic [ADDR_W-1:0] head_addr
);

   localparam int PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMDQ_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CMDQ_DEPTH);

   cmd_type           cmd_ff  [CMDQ_DEPTH];
   logic [ADDR_W-1:0] addr_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_cmd  = cmd_ff[rd_ptr_ff];
   assign head_addr = addr_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         cmd_ff[wr_ptr_ff]  <= push_cmd;
         addr_ff[wr_ptr_ff] <= push_addr;
      end
   end

endmodule

// ----- rtl/core/tmcg_back.sv -----
module tmcg_back
   import tmcg_pkg::*;
#(
   parameter int GLYPH_ROWS = GLYPH_ROWS_DEFAULT,
   parameter int FONT_BANKS = FONT_BANKS_DEFAULT,
   localparam int ADDR_W = $clog2(FONT_BANKS * CHAR_COUNT * GLYPH_ROWS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  cmd_type           q_cmd,
   input  logic [ADDR_W-1:0] q_addr,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output pixel_row_type     rsp_pixels
);

   localparam int STORE_DEPTH = FONT_BANKS * CHAR_COUNT * GLYPH_ROWS;
   localparam int PTR_W = $clog2(OUT_DEPTH);
   localparam int CNT_W = $clog2(OUT_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(OUT_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(OUT_DEPTH);

   logic [BYTE_W-1:0] font_mem_ff [STORE_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;
   logic              s1_valid_ff, s1_valid_in;
   cmd_type           s1_cmd_ff;

   pixel_row_type     out_ff [OUT_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic              mem_we, mem_re;
   logic              room;
   logic              out_pop;
   logic [BYTE_W-1:0] glyph;
   pixel_row_type     pixels;

   // reserve a slot for the read still in flight
   assign room   = (count_ff + CNT_W'(s1_valid_ff)) < CNT_FULL;
   assign q_pop  = !q_empty && (q_cmd.is_write || room);
   assign mem_we = q_pop && q_cmd.is_write;
   assign mem_re = q_pop && !q_cmd.is_write;
   assign s1_valid_in = mem_re;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         font_mem_ff[q_addr] <= q_cmd.data;
      end
      if (mem_re) begin
         rd_data_ff <= font_mem_ff[q_addr];
         s1_cmd_ff  <= q_cmd;
      end
   end

   always_comb begin
      priority if (s1_cmd_ff.fill) begin
         glyph = '1;
      end else if (s1_cmd_ff.glyph_off) begin
         glyph = '0;
      end else begin
         glyph = rd_data_ff;
      end
      for (int k = 0; k < PIXELS; k++) begin
         pixels[k] = glyph[PIXELS-1-k] ? s1_cmd_ff.data[COLOR_W-1:0]
                                        : s1_cmd_ff.data[BYTE_W-1:COLOR_W];
      end
   end

   assign rsp_empty  = (count_ff == '0);
   assign out_pop    = rsp_pop && !rsp_empty;
   assign rsp_pixels = out_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (s1_valid_ff) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (out_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (s1_valid_ff && !out_pop) begin
         count_in = count_ff + 1'b1;
      end else if (out_pop && !s1_valid_ff) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         out_ff[wr_ptr_ff] <= pixels;
      end
   end

endmodule

// ----- rtl/core/text_mode_character_generator.sv -----
// Text mode character generator: one text cell in, eight 4-bit color indices out.
// Input queue (req_push/req_full): a transaction is a font write, a render cell or a
// frame tick. Only render cells produce a result; font writes load the glyph store
// and frame ticks advance the 8-bit blink/cursor frame counter.
// Result queue (rsp_empty/rsp_pop): pixels of the oldest render, pixel_0 leftmost,
// shown while rsp_empty is low and retired by rsp_pop.
// Register port (csr_valid/csr_ready): csr_ready is always high; index 0 blink
// enable, 1 cursor enable, 2 cursor start row, 3 cursor end row. Write only while idle.
// Path: a render accepted into the command queue is read from the registered glyph
// store once the result queue has room, and is then written into the result queue,
// from which it can be popped.
// Throughput: one transaction per cycle while req_full is low, limited by the single
// port of the glyph store, which takes one font write or one render read per cycle.
// When the receiver stalls, the result queue and then the command queue fill and
// req_full rises; nothing is dropped.
// Reset clears the frame counter, loads the register defaults (blink on, cursor off,
// rows 0) and empties both queues; glyph store contents are unknown until written.
module text_mode_character_generator
   import tmcg_pkg::*;
#(
   parameter int GLYPH_ROWS = GLYPH_ROWS_DEFAULT,
   parameter int FONT_BANKS = FONT_BANKS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [1:0]             req_kind,
   input  logic [BYTE_W-1:0]      req_char_code,
   input  logic [BYTE_W-1:0]      req_attribute,
   input  logic [ROW_W-1:0]       req_row,
   input  logic                   req_is_cursor_cell,
   input  logic                   req_font_bank,
   input  logic [BYTE_W-1:0]      req_font_byte,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [COLOR_W-1:0]     rsp_pixel_0,
   output logic [COLOR_W-1:0]     rsp_pixel_1,
   output logic [COLOR_W-1:0]     rsp_pixel_2,
   output logic [COLOR_W-1:0]     rsp_pixel_3,
   output logic [COLOR_W-1:0]     rsp_pixel_4,
   output logic [COLOR_W-1:0]     rsp_pixel_5,
   output logic [COLOR_W-1:0]     rsp_pixel_6,
   output logic [COLOR_W-1:0]     rsp_pixel_7,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int ADDR_W = $clog2(FONT_BANKS * CHAR_COUNT * GLYPH_ROWS);

   logic              push;
   cmd_type           push_cmd;
   logic [ADDR_W-1:0] push_addr;
   logic              q_empty;
   logic              q_pop;
   cmd_type           head_cmd;
   logic [ADDR_W-1:0] head_addr;
   pixel_row_type     pixels;

   assign csr_ready = 1'b1;

   tmcg_front #(
      .GLYPH_ROWS(GLYPH_ROWS),
      .FONT_BANKS(FONT_BANKS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .q_full             (req_full),
      .req_kind           (req_kind),
      .req_char_code      (req_char_code),
      .req_attribute      (req_attribute),
      .req_row            (req_row),
      .req_is_cursor_cell (req_is_cursor_cell),
      .req_font_bank      (req_font_bank),
      .req_font_byte      (req_font_byte),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .q_push             (push),
      .q_cmd              (push_cmd),
      .q_addr             (push_addr)
   );

   tmcg_cmdq #(
      .GLYPH_ROWS(GLYPH_ROWS),
      .FONT_BANKS(FONT_BANKS)
   ) u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .push_addr (push_addr),
      .full      (req_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_cmd  (head_cmd),
      .head_addr (head_addr)
   );

   tmcg_back #(
      .GLYPH_ROWS(GLYPH_ROWS),
      .FONT_BANKS(FONT_BANKS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_cmd      (head_cmd),
      .q_addr     (head_addr),
      .q_pop      (q_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_pixels (pixels)
   );

   assign rsp_pixel_0 = pixels[0];
   assign rsp_pixel_1 = pixels[1];
   assign rsp_pixel_2 = pixels[2];
   assign rsp_pixel_3 = pixels[3];
   assign rsp_pixel_4 = pixels[4];
   assign rsp_pixel_5 = pixels[5];
   assign rsp_pixel_6 = pixels[6];
   assign rsp_pixel_7 = pixels[7];

endmodule

// ----- test/text_mode_character_generator_tb.sv -----
module text_mode_character_generator_tb;
   import tmcg_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int STALL_LIMIT      = 2000;
   localparam int SETTLE_CYCLES    = 8;
   localparam int RANDOM_PER_PHASE = 70;
   localparam int PHASES           = 6;
   localparam int MAX_REPORTS      = 10;

   typedef struct packed {
      logic [1:0]         kind;
      logic [BYTE_W-1:0]  char_code;
      logic [BYTE_W-1:0]  attribute;
      logic [ROW_W-1:0]   row;
      logic               cursor_cell;
      logic               font_bank;
      logic [BYTE_W-1:0]  font_byte;
   } cell_cmd_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic [1:0]             req_kind = '0;
   logic [BYTE_W-1:0]      req_char_code = '0;
   logic [BYTE_W-1:0]      req_attribute = '0;
   logic [ROW_W-1:0]       req_row = '0;
   logic                   req_is_cursor_cell = 1'b0;
   logic                   req_font_bank = 1'b0;
   logic [BYTE_W-1:0]      req_font_byte = '0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [COLOR_W-1:0]     rsp_pixel_0, rsp_pixel_1, rsp_pixel_2, rsp_pixel_3;
   logic [COLOR_W-1:0]     rsp_pixel_4, rsp_pixel_5, rsp_pixel_6, rsp_pixel_7;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // mirror of the generator state
   logic [BYTE_W-1:0]  glyph_copy [0:16383];
   logic [BYTE_W-1:0]  frame_counter = '0;
   logic               blink_on = 1'b1;
   logic               cursor_shown = 1'b0;
   logic [ROW_W-1:0]   cursor_first = '0;
   logic [ROW_W-1:0]   cursor_last = '0;

   // glyph entries written so far, known at generation time
   bit                 glyph_loaded [0:16383];
   logic [13:0]        loaded_entries [$];

   cell_cmd_type       cell_cmds_pending [$];
   pixel_row_type      pixel_rows_due [$];
   cell_cmd_type       bus_cmd;

   int                 send_gap = 0;
   bit                 send_burst = 1'b0;
   int                 pop_wait = 0;
   bit                 recv_burst = 1'b0;
   int                 mismatch_count = 0;
   int                 stall_cycles = 0;

   text_mode_character_generator dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_kind           (req_kind),
      .req_char_code      (req_char_code),
      .req_attribute      (req_attribute),
      .req_row            (req_row),
      .req_is_cursor_cell (req_is_cursor_cell),
      .req_font_bank      (req_font_bank),
      .req_font_byte      (req_font_byte),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_pixel_0        (rsp_pixel_0),
      .rsp_pixel_1        (rsp_pixel_1),
      .rsp_pixel_2        (rsp_pixel_2),
      .rsp_pixel_3        (rsp_pixel_3),
      .rsp_pixel_4        (rsp_pixel_4),
      .rsp_pixel_5        (rsp_pixel_5),
      .rsp_pixel_6        (rsp_pixel_6),
      .rsp_pixel_7        (rsp_pixel_7),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int draw_gap(bit burst);
      return burst ? 0 : $urandom_range(0, 19);
   endfunction

   function automatic pixel_row_type render_pixels(cell_cmd_type c);
      logic [BYTE_W-1:0]  glyph;
      logic [COLOR_W-1:0] fg;
      logic [COLOR_W-1:0] bg;
      logic               cursor_hit;
      pixel_row_type      px;
      glyph = glyph_copy[{c.attribute[3], c.char_code, c.row}];
      fg = c.attribute[3:0];
      bg = c.attribute[7:4];
      if (blink_on) begin
         bg[3] = 1'b0;
         if (c.attribute[7] && frame_counter[4])
            glyph = '0;
      end
      cursor_hit = cursor_shown && frame_counter[3] && c.cursor_cell &&
                   c.row >= cursor_first && c.row <= cursor_last;
      if (cursor_hit)
         glyph = 8'hff;
      for (int k = 0; k < PIXELS; k++)
         px[k] = glyph[7-k] ? fg : bg;
      return px;
   endfunction

   function automatic void commit_cell_cmd(cell_cmd_type c);
      case (c.kind)
         KIND_FONT_WRITE: glyph_copy[{c.font_bank, c.char_code, c.row}] = c.font_byte;
         KIND_FRAME_TICK: frame_counter = frame_counter + 8'd1;
         KIND_RENDER:     pixel_rows_due.push_back(render_pixels(c));
         default: ;
      endcase
   endfunction

   task automatic queue_cmd(cell_cmd_type c);
      logic [13:0] entry;
      entry = {c.font_bank, c.char_code, c.row};
      if (c.kind == KIND_FONT_WRITE && !glyph_loaded[entry]) begin
         glyph_loaded[entry] = 1'b1;
         loaded_entries.push_back(entry);
      end
      cell_cmds_pending.push_back(c);
   endtask

   task automatic queue_fields(logic [1:0] kind, logic [7:0] chr, logic [7:0] attr,
                               logic [4:0] row, logic cur, logic bank, logic [7:0] fbyte);
      cell_cmd_type c;
      c.kind = kind;
      c.char_code = chr;
      c.attribute = attr;
      c.row = row;
      c.cursor_cell = cur;
      c.font_bank = bank;
      c.font_byte = fbyte;
      queue_cmd(c);
   endtask

   task automatic queue_random_cmd();
      cell_cmd_type c;
      int           pick;
      logic [13:0]  entry;
      pick = $urandom_range(0, 99);
      c.char_code = BYTE_W'($urandom_range(0, 255));
      c.attribute = BYTE_W'($urandom_range(0, 255));
      c.row = ROW_W'($urandom_range(0, 31));
      c.cursor_cell = 1'($urandom_range(0, 1));
      c.font_bank = 1'($urandom_range(0, 1));
      c.font_byte = BYTE_W'($urandom_range(0, 255));
      if (pick < 30 || loaded_entries.size() == 0) begin
         c.kind = KIND_FONT_WRITE;
      end else if (pick < 75) begin
         // aim only at glyph rows that have been loaded
         c.kind = KIND_RENDER;
         entry = loaded_entries[$urandom_range(0, loaded_entries.size() - 1)];
         c.attribute[3] = entry[13];
         c.char_code = entry[12:5];
         c.row = entry[4:0];
      end else if (pick < 95) begin
         c.kind = KIND_FRAME_TICK;
      end else begin
         c.kind = KIND_UNUSED;
      end
      queue_cmd(c);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_BLINK_ENABLE:     blink_on = value[0];
         CSR_CURSOR_ENABLE:    cursor_shown = value[0];
         CSR_CURSOR_START_ROW: cursor_first = value[ROW_W-1:0];
         CSR_CURSOR_END_ROW:   cursor_last = value[ROW_W-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_until_idle();
      @(negedge clock);
      while (cell_cmds_pending.size() != 0 || req_push || pixel_rows_due.size() != 0)
         @(negedge clock);
      // let font writes and ticks drain out of the pipeline
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : drive_proc
      logic push_next;
      if (reset) begin
         req_push <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_push && !req_full)
            commit_cell_cmd(bus_cmd);
         if (req_push && req_full) begin
            push_next = 1'b1;
         end else if (send_gap > 0) begin
            send_gap = send_gap - 1;
            push_next = 1'b0;
         end else if (cell_cmds_pending.size() != 0) begin
            bus_cmd = cell_cmds_pending.pop_front();
            req_kind <= bus_cmd.kind;
            req_char_code <= bus_cmd.char_code;
            req_attribute <= bus_cmd.attribute;
            req_row <= bus_cmd.row;
            req_is_cursor_cell <= bus_cmd.cursor_cell;
            req_font_bank <= bus_cmd.font_bank;
            req_font_byte <= bus_cmd.font_byte;
            push_next = 1'b1;
            send_gap = draw_gap(send_burst);
            if ($urandom_range(0, 24) == 0)
               send_burst = !send_burst;
         end else begin
            push_next = 1'b0;
         end
         req_push <= push_next;
      end
   end

   always @(posedge clock) begin : check_proc
      pixel_row_type seen;
      pixel_row_type due;
      bit            bad;
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_wait = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            seen = {rsp_pixel_7, rsp_pixel_6, rsp_pixel_5, rsp_pixel_4,
                    rsp_pixel_3, rsp_pixel_2, rsp_pixel_1, rsp_pixel_0};
            if (pixel_rows_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected pixel row %h", seen);
            end else begin
               due = pixel_rows_due.pop_front();
               bad = 1'b0;
               for (int k = 0; k < PIXELS; k++)
                  if (seen[k] !== due[k])
                     bad = 1'b1;
               if (bad) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("pixel row mismatch: expected %h actual %h (pixel_7..pixel_0)",
                              due, seen);
               end
            end
            pop_wait = draw_gap(recv_burst);
            if ($urandom_range(0, 24) == 0)
               recv_burst = !recv_burst;
         end else if (pop_wait > 0) begin
            pop_wait = pop_wait - 1;
         end
         rsp_pop <= (pop_wait == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin : watchdog
      @(negedge clock);
      while (stall_cycles < STALL_LIMIT)
         @(negedge clock);
      $display("Some tests failed");
      $finish;
   end

   initial begin : main_seq
      logic       blink_set;
      logic       cursor_set;
      logic [4:0] first_set;
      logic [4:0] last_set;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_until_idle();
         case (phase)
            0: begin
               blink_set = 1'b1; cursor_set = 1'b1; first_set = 5'd0;  last_set = 5'd31;
            end
            1: begin
               blink_set = 1'b0; cursor_set = 1'b1; first_set = 5'd5;  last_set = 5'd12;
            end
            2: begin
               blink_set = 1'b1; cursor_set = 1'b1; first_set = 5'd31; last_set = 5'd31;
            end
            3: begin
               blink_set = 1'b1; cursor_set = 1'b0; first_set = 5'd0;  last_set = 5'd0;
            end
            4: begin
               // start above end: no cursor at all
               blink_set = 1'b0; cursor_set = 1'b1; first_set = 5'd20; last_set = 5'd3;
            end
            default: begin
               blink_set = 1'($urandom_range(0, 1));
               cursor_set = 1'($urandom_range(0, 1));
               first_set = 5'($urandom_range(0, 31));
               last_set = 5'($urandom_range(0, 31));
            end
         endcase
         write_reg(CSR_BLINK_ENABLE, {4'd0, blink_set});
         write_reg(CSR_CURSOR_ENABLE, {4'd0, cursor_set});
         write_reg(CSR_CURSOR_START_ROW, first_set);
         write_reg(CSR_CURSOR_END_ROW, last_set);
         @(negedge clock);
         if (phase == 0) begin
            queue_fields(KIND_FONT_WRITE, 8'h00, 8'h00, 5'd0,  1'b0, 1'b0, 8'h00);
            queue_fields(KIND_FONT_WRITE, 8'hff, 8'hff, 5'd31, 1'b1, 1'b1, 8'hff);
            queue_fields(KIND_FONT_WRITE, 8'h41, 8'h00, 5'd5,  1'b0, 1'b0, 8'ha5);
            queue_fields(KIND_FONT_WRITE, 8'h41, 8'h00, 5'd5,  1'b0, 1'b1, 8'h5a);
            // unused kind: drop without a result
            queue_fields(KIND_UNUSED,     8'hff, 8'hff, 5'd31, 1'b1, 1'b1, 8'hff);
            queue_fields(KIND_RENDER,     8'h00, 8'h00, 5'd0,  1'b0, 1'b0, 8'h00);
            queue_fields(KIND_RENDER,     8'hff, 8'hff, 5'd31, 1'b1, 1'b0, 8'h00);
            queue_fields(KIND_RENDER,     8'h41, 8'h07, 5'd5,  1'b1, 1'b0, 8'h00);
            queue_fields(KIND_RENDER,     8'h41, 8'h8f, 5'd5,  1'b0, 1'b0, 8'h00);
            // advance to cursor phase, then to blink phase
            repeat (8) queue_fields(KIND_FRAME_TICK, 8'h00, 8'h00, 5'd0, 1'b0, 1'b0, 8'h00);
            queue_fields(KIND_RENDER,     8'hff, 8'hf8, 5'd31, 1'b1, 1'b0, 8'h00);
            queue_fields(KIND_RENDER,     8'h41, 8'h27, 5'd5,  1'b0, 1'b0, 8'h00);
            repeat (8) queue_fields(KIND_FRAME_TICK, 8'h00, 8'h00, 5'd0, 1'b0, 1'b0, 8'h00);
            queue_fields(KIND_RENDER,     8'h41, 8'h8f, 5'd5,  1'b0, 1'b0, 8'h00);
            queue_fields(KIND_RENDER,     8'hff, 8'hff, 5'd31, 1'b1, 1'b0, 8'h00);
         end
         repeat (RANDOM_PER_PHASE) queue_random_cmd();
      end
      wait_until_idle();
      if (mismatch_count == 0 && pixel_rows_due.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
